// ===== rtl/hsng_pkg.sv =====
// ----------------------------------------------------------------------------
// hsng_pkg - shared constants and types for the heightmap strip normal block
// Field widths, stream packing offsets, register codes and the job record
// handed from the line-buffer stage to the vertex emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsng_pkg;

  localparam int HEIGHT_BITS     = 16;
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_ROWS    = 1024;

  localparam int CFG_W           = 11;
  localparam int POS_W           = 10;
  localparam int NRM_W           = HEIGHT_BITS + 2;
  localparam int NY_W            = 11;
  localparam int LIM_W           = 16;   // compare width for counts and limits
  localparam int WORD_W          = 3 * HEIGHT_BITS;

  localparam logic [NY_W-1:0]  NORMAL_Y  = NY_W'(1024);  // 4.0 in Q3.8
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

  // stream packing
  localparam int IN_DATA_W   = ((HEIGHT_BITS + 7) / 8) * 8;
  localparam int X_LSB       = 0;
  localparam int Z_LSB       = X_LSB + POS_W;
  localparam int Y_LSB       = Z_LSB + POS_W;
  localparam int NX_LSB      = Y_LSB + HEIGHT_BITS;
  localparam int NY_LSB      = NX_LSB + NRM_W;
  localparam int NZ_LSB      = NY_LSB + NY_W;
  localparam int OUT_FIELD_W = NZ_LSB + NRM_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // APB register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_GRID_WIDTH = 1'b0;
  localparam logic REG_GRID_ROWS  = 1'b1;

  typedef struct packed {
    logic [HEIGHT_BITS-1:0] y;
    logic [NRM_W-1:0]       nx;
    logic [NRM_W-1:0]       nz;
  } vertex_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] z;
    logic             dup_a;    // row start: vertex a sent twice
    logic             extra_b;  // row end: closing vertex b
    vertex_t          va;
    vertex_t          vb;
  } job_t;

  // 2*(a - b) for signed heights, exact in NRM_W bits
  function automatic logic [NRM_W-1:0] dbl_diff(input logic [HEIGHT_BITS-1:0] a,
                                                input logic [HEIGHT_BITS-1:0] b);
    logic [HEIGHT_BITS:0] d;
    d = {a[HEIGHT_BITS-1], a} - {b[HEIGHT_BITS-1], b};
    return {d, 1'b0};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hsng_line_mem.sv =====
// ----------------------------------------------------------------------------
// hsng_line_mem - three-row line buffer
// One word per column holds rows r-1, r-2 and r-3; one write port and two
// read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hsng_line_mem
  import hsng_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_WIDTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr_a,
  input  wire logic [ADDR_W-1:0] rd_addr_b,
  output logic      [WORD_W-1:0] rd_data_a,
  output logic      [WORD_W-1:0] rd_data_b,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hsng_emit.sv =====
// ----------------------------------------------------------------------------
// hsng_emit - strip vertex sequencer and output register
// Holds one job and sends its two to four vertices, one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module hsng_emit
  import hsng_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire job_t                  job_in,
  output logic                       job_ready,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // pos_x, pos_z, pos_y, normal_x, normal_y, normal_z, zero pad (LSB first)
  output logic      [OUT_DATA_W-1:0] m_tdata,
  output logic                       m_tlast
);

  logic       busy;
  job_t       job;
  logic [1:0] idx;
  logic [1:0] last_idx;
  logic       out_free;
  logic       step;
  logic       done;
  logic       is_a;
  vertex_t    vsel;
  logic [POS_W-1:0] zsel;

  assign last_idx  = 2'd1 + {1'b0, job.dup_a} + {1'b0, job.extra_b};
  assign out_free  = !m_tvalid || m_tready;
  assign step      = busy && out_free;
  assign done      = step && (idx == last_idx);
  assign job_ready = !busy || done;

  // order a,(a),b,(b)
  assign is_a = (idx == 2'd0) || ((idx == 2'd1) && job.dup_a);
  assign vsel = is_a ? job.va : job.vb;
  assign zsel = is_a ? job.z : job.z + POS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
      idx      <= 2'd0;
    end else begin
      if (step) begin
        m_tvalid <= 1'b1;
        idx      <= idx + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (done) begin
        busy <= 1'b0;
      end
      if (push) begin
        busy <= 1'b1;
        idx  <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      job <= job_in;
    end
    if (step) begin
      m_tdata <= OUT_DATA_W'({vsel.nz, NORMAL_Y, vsel.nx, vsel.y, zsel, job.x});
      m_tlast <= (idx == last_idx);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/heightmap_strip_normal_generator.sv =====
// Path: line-buffer stage register, emitter job register, output register.
// Throughput: one sample per cycle while nothing is emitted; an emitting sample
// waits on the single output register, which sends one vertex per transfer: two
// for an interior sample, three at a row start or end, four on a one-column-wide
// strip. Reset: synchronous, clears counters, pipeline valids and registers to
// 1024; line buffers are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// heightmap_strip_normal_generator - triangle strip vertices with normals
// Line-buffered raster walk over a height grid; reads columns c and c+1 of
// the three-row buffer, shifts column c and forms central-difference normals.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_strip_normal_generator
  import hsng_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_ROWS  = DEF_MAX_ROWS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // height sample stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // height_sample, zero pad
  // vertex stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // pos_x, pos_z, pos_y, normal_x, normal_y, normal_z, zero pad (LSB first)
  output logic      [OUT_DATA_W-1:0] m_tdata,
  output logic                       m_tlast,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int H     = HEIGHT_BITS;

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_rows;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= CFG_RESET;
      grid_rows  <= CFG_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_GRID_WIDTH: grid_width <= pwdata[CFG_W-1:0];
        REG_GRID_ROWS:  grid_rows  <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GRID_WIDTH: prdata = APB_DATA_W'(grid_width);
      REG_GRID_ROWS:  prdata = APB_DATA_W'(grid_rows);
    endcase
  end

  logic [LIM_W-1:0] w_l;
  logic [LIM_W-1:0] rows_l;

  always_comb begin
    if (grid_width == '0) begin
      w_l = LIM_W'(1);
    end else if (LIM_W'(grid_width) > LIM_W'(MAX_WIDTH)) begin
      w_l = LIM_W'(MAX_WIDTH);
    end else begin
      w_l = LIM_W'(grid_width);
    end
    if (grid_rows == '0) begin
      rows_l = LIM_W'(1);
    end else if (LIM_W'(grid_rows) > LIM_W'(MAX_ROWS)) begin
      rows_l = LIM_W'(MAX_ROWS);
    end else begin
      rows_l = LIM_W'(grid_rows);
    end
  end

  // ---------------- raster position ----------------
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [LIM_W-1:0] col_l;
  logic [LIM_W-1:0] row_l;
  logic             in_xfer;
  logic             col_wrap;
  logic             row_wrap;
  logic             emit0;
  logic             dup0;
  logic             extra0;
  logic [COL_W-1:0] addr_b0;
  logic [LIM_W-1:0] z0_l;

  assign col_l    = LIM_W'(col);
  assign row_l    = LIM_W'(row);
  assign in_xfer  = s_tvalid && s_tready;
  assign col_wrap = (col_l + LIM_W'(1)) >= w_l;
  assign row_wrap = (row_l + LIM_W'(1)) >= rows_l;

  assign emit0  = (w_l >= LIM_W'(3)) && (row_l >= LIM_W'(3)) && (col_l >= LIM_W'(1))
                  && ((col_l + LIM_W'(2)) <= w_l);
  assign dup0   = (col_l == LIM_W'(1)) && (row_l > LIM_W'(3));
  assign extra0 = ((col_l + LIM_W'(2)) == w_l) && !row_wrap;
  assign z0_l   = row_l - LIM_W'(2);
  // c+1 past the buffer end only happens on the last column, where it is unused
  assign addr_b0 = ((col_l + LIM_W'(1)) >= LIM_W'(MAX_WIDTH)) ? '0 : col + COL_W'(1);

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      col <= '0;
      row <= '0;
    end else if (in_xfer) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // ---------------- line buffer stage ----------------
  logic             s1_valid;
  logic             s1_emit;
  logic             s1_dup;
  logic             s1_extra;
  logic [H-1:0]     s1_h;
  logic [COL_W-1:0] s1_addr_a;
  logic [COL_W-1:0] s1_addr_b;
  logic [POS_W-1:0] s1_x;
  logic [POS_W-1:0] s1_z;
  logic             s1_adv;
  logic             job_ready;
  logic             job_push;

  logic [WORD_W-1:0] rd_a;
  logic [WORD_W-1:0] rd_b;
  logic [WORD_W-1:0] word_a;
  logic [WORD_W-1:0] word_b;
  logic [WORD_W-1:0] word_new;

  logic              last_wr_valid;
  logic [COL_W-1:0]  last_wr_addr;
  logic [WORD_W-1:0] last_wr_data;

  logic [H-1:0] prev_m1;
  logic [H-1:0] prev_m2;
  logic [H-1:0] m1;
  logic [H-1:0] m2;
  logic [H-1:0] m3;
  logic [H-1:0] n1;
  logic [H-1:0] n2;
  job_t         job;

  assign s1_adv   = s1_valid && (!s1_emit || job_ready);
  assign s_tready = !s1_valid || s1_adv;
  assign job_push = s1_adv && s1_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_emit   <= emit0;
      s1_dup    <= dup0;
      s1_extra  <= extra0;
      s1_h      <= s_tdata[H-1:0];
      s1_addr_a <= col;
      s1_addr_b <= addr_b0;
      s1_x      <= col_l[POS_W-1:0];
      s1_z      <= z0_l[POS_W-1:0];
    end
  end

  hsng_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_mem (
    .clk       (clk),
    .rd_en     (in_xfer),
    .rd_addr_a (col),
    .rd_addr_b (addr_b0),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b),
    .wr_en     (s1_adv),
    .wr_addr   (s1_addr_a),
    .wr_data   (word_new)
  );

  // the read may have been issued on the edge of the previous write
  assign word_a = (last_wr_valid && last_wr_addr == s1_addr_a) ? last_wr_data : rd_a;
  assign word_b = (last_wr_valid && last_wr_addr == s1_addr_b) ? last_wr_data : rd_b;

  // word layout: [H-1:0] row r-1, [2H-1:H] row r-2, [3H-1:2H] row r-3
  assign m1 = word_a[H-1:0];
  assign m2 = word_a[2*H-1:H];
  assign m3 = word_a[3*H-1:2*H];
  assign n1 = word_b[H-1:0];
  assign n2 = word_b[2*H-1:H];
  assign word_new = {m2, m1, s1_h};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_wr_valid <= 1'b0;
    end else if (s1_adv) begin
      last_wr_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      last_wr_addr <= s1_addr_a;
      last_wr_data <= word_new;
      prev_m1      <= m1;
      prev_m2      <= m2;
    end
  end

  always_comb begin
    job.x       = s1_x;
    job.z       = s1_z;
    job.dup_a   = s1_dup;
    job.extra_b = s1_extra;
    job.va.y    = m2;
    job.va.nx   = dbl_diff(prev_m2, n2);
    job.va.nz   = dbl_diff(m3, m1);
    job.vb.y    = m1;
    job.vb.nx   = dbl_diff(prev_m1, n1);
    job.vb.nz   = dbl_diff(m2, s1_h);
  end

  hsng_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .job_in    (job),
    .job_ready (job_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/hsng_checker.sv =====
// ----------------------------------------------------------------------------
// hsng_checker - port-level checks for the heightmap strip normal block
// Watches the streams only; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module hsng_checker
  import hsng_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic                  m_tlast
);

  // stalled vertex holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("vertex changed while stalled");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not empty after reset");

  a_normal_y: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[NY_LSB +: NY_W] == NORMAL_Y)
    else $error("normal y not 4.0");

  // interior points only: never column 0 or row 0
  a_interior: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[X_LSB +: POS_W] != '0 && m_tdata[Z_LSB +: POS_W] != '0)
    else $error("vertex on the grid border");

endmodule

bind heightmap_strip_normal_generator hsng_checker u_hsng_checker (.*);

`default_nettype wire
